[rtl/core/tws_pkg.sv]
`default_nettype none
package tws_pkg;

	// fixed field widths
	localparam int CMD_W      = 2;
	localparam int KIND_W     = 2;
	localparam int HANDLE_W   = 32;
	localparam int OUT_TIME_W = 48;
	localparam int WIN_W      = 48;
	localparam int COUNT_W    = 6;
	localparam int CFG_IDX_W  = 1;

	// parameter defaults
	localparam int DEPTH_DEF     = 32;
	localparam int TIME_BITS_DEF = 48;

	localparam logic [WIN_W-1:0] WINDOW_RST = 48'd1000000000;

	// commands
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_EMIT   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLUSH  = 1'd1;

	// per-cycle operation broadcast to every cell
	typedef struct packed {
		logic ins;   // sorted insert of the broadcast hit
		logic shl;   // shift toward cell 0 (release the oldest)
	} tws_op_t;

endpackage
`default_nettype wire

[rtl/core/tws_cell.sv]
`default_nettype none
module tws_cell #(
	parameter int TIME_BITS = tws_pkg::TIME_BITS_DEF
) (
	input  wire                            clk,
	input  wire tws_pkg::tws_op_t          op,
	input  wire [TIME_BITS-1:0]            ins_time,
	input  wire [tws_pkg::HANDLE_W-1:0]    ins_handle,
	input  wire                            valid,
	input  wire                            left_valid,
	input  wire                            left_greater,
	input  wire [TIME_BITS-1:0]            left_time,
	input  wire [tws_pkg::HANDLE_W-1:0]    left_handle,
	input  wire [TIME_BITS-1:0]            right_time,
	input  wire [tws_pkg::HANDLE_W-1:0]    right_handle,
	output logic                           greater,
	output logic [TIME_BITS-1:0]           cell_time,
	output logic [tws_pkg::HANDLE_W-1:0]   cell_handle
);
	import tws_pkg::*;

	logic [TIME_BITS-1:0] time_q;
	logic [HANDLE_W-1:0]  handle_q;

	// strictly greater: equal times stay ahead of the new hit
	assign greater     = valid && (time_q > ins_time);
	assign cell_time   = time_q;
	assign cell_handle = handle_q;

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (left_greater) begin
				time_q   <= left_time;
				handle_q <= left_handle;
			end else if (greater || (!valid && left_valid)) begin
				time_q   <= ins_time;
				handle_q <= ins_handle;
			end
		end else if (op.shl) begin
			time_q   <= right_time;
			handle_q <= right_handle;
		end
	end

endmodule
`default_nettype wire

[rtl/core/time_window_hit_sorter_unit.sv]
// Channel  | Handshake                    | Word
// ---------+------------------------------+-------------------------------------
// command  | start & !busy                | command, hit_time, hit_handle
// result   | result_valid (one cycle)     | kind, out_time, out_handle, last,
//          |                              | held_count
// config   | cfg_valid & cfg_ready        | cfg_index, cfg_data
//
// Insert and clear never raise busy, so a new word can follow
// at once. A rejected insert shows its result the cycle after accept.
// Emit holds busy while hits are released, one release per cycle as the cell
// chain shifts toward cell 0, and then while the last result is flagged.
// Reset clears the fill count, state and config; cell contents are not reset.
// The receiver cannot stall: every result word stands for exactly one cycle.
`default_nettype none
module time_window_hit_sorter_unit #(
	parameter int DEPTH     = tws_pkg::DEPTH_DEF,
	parameter int TIME_BITS = tws_pkg::TIME_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// command channel
	input  wire                               start,
	output logic                              busy,
	input  wire [tws_pkg::CMD_W-1:0]          command,
	input  wire [TIME_BITS-1:0]               hit_time,
	input  wire [tws_pkg::HANDLE_W-1:0]       hit_handle,
	// result channel
	output logic                              result_valid,
	output logic [tws_pkg::KIND_W-1:0]        kind,
	output logic [tws_pkg::OUT_TIME_W-1:0]    out_time,
	output logic [tws_pkg::HANDLE_W-1:0]      out_handle,
	output logic                              last,
	output logic [tws_pkg::COUNT_W-1:0]       held_count,
	// config channel
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [tws_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [tws_pkg::WIN_W-1:0]          cfg_data
);
	import tws_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIME_BITS-1:0] newest_q;   // time of the newest held hit
	logic [WIN_W-1:0]     window_q;
	logic                 flush_q;

	// release waiting for the next decision (tells whether it is last)
	logic                 pend_valid_q;
	logic [TIME_BITS-1:0] pend_time_q;
	logic [HANDLE_W-1:0]  pend_handle_q;
	logic [CNT_W-1:0]     pend_count_q;

	// result registers
	logic                  strobe_q;
	logic [KIND_W-1:0]     kind_q;
	logic [OUT_TIME_W-1:0] time_q;
	logic [HANDLE_W-1:0]   handle_q;
	logic                  last_q;
	logic [COUNT_W-1:0]    count_out_q;

	// cell chain
	logic [TIME_BITS-1:0] cell_time   [DEPTH];
	logic [HANDLE_W-1:0]  cell_handle [DEPTH];
	logic [DEPTH-1:0]     cell_greater;
	logic [DEPTH-1:0]     cell_valid;
	tws_op_t              op;

	logic                 accept;
	logic                 full;
	logic                 ready_rel;
	logic [TIME_BITS-1:0] span;

	assign busy      = (state_q == ST_EMIT);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign full      = (count_q == FULL_CNT);

	// newest minus oldest never wraps: the chain is sorted
	assign span      = newest_q - cell_time[0];
	assign ready_rel = (count_q != '0) &&
		(flush_q || ((count_q > CNT_W'(1)) && (CMP_W'(span) > CMP_W'(window_q))));

	assign op.ins = accept && (command == CMD_INSERT) && !full;
	assign op.shl = busy && ready_rel;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                 lv, lg;
			logic [TIME_BITS-1:0] lt, rt;
			logic [HANDLE_W-1:0]  lh, rh;

			assign cell_valid[gi] = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_head
				assign lv = 1'b1;
				assign lg = 1'b0;
				assign lt = hit_time;
				assign lh = hit_handle;
			end else begin : g_body
				assign lv = cell_valid[gi-1];
				assign lg = cell_greater[gi-1];
				assign lt = cell_time[gi-1];
				assign lh = cell_handle[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign rt = cell_time[gi];
				assign rh = cell_handle[gi];
			end else begin : g_mid
				assign rt = cell_time[gi+1];
				assign rh = cell_handle[gi+1];
			end

			tws_cell #(
				.TIME_BITS(TIME_BITS)
			) u_cell (
				.clk          (clk),
				.op           (op),
				.ins_time     (hit_time),
				.ins_handle   (hit_handle),
				.valid        (cell_valid[gi]),
				.left_valid   (lv),
				.left_greater (lg),
				.left_time    (lt),
				.left_handle  (lh),
				.right_time   (rt),
				.right_handle (rh),
				.greater      (cell_greater[gi]),
				.cell_time    (cell_time[gi]),
				.cell_handle  (cell_handle[gi])
			);
		end
	endgenerate

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			window_q     <= WINDOW_RST;
			flush_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW: window_q <= cfg_data;
					REG_FLUSH:  flush_q  <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (command)
							CMD_INSERT: begin
								if (full) begin
									strobe_q <= 1'b1;
								end else begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_EMIT: begin
								state_q      <= ST_EMIT;
								pend_valid_q <= 1'b0;
							end
							CMD_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				ST_EMIT: begin
					if (ready_rel) begin
						count_q      <= count_q - CNT_W'(1);
						pend_valid_q <= 1'b1;
						strobe_q     <= pend_valid_q;
					end else begin
						strobe_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (op.ins) begin
			if ((count_q == '0) || (hit_time > newest_q)) begin
				newest_q <= hit_time;
			end
		end
		case (state_q)
			ST_IDLE: begin
				// full-store reject
				kind_q      <= KIND_REJECT;
				time_q      <= OUT_TIME_W'(hit_time);
				handle_q    <= hit_handle;
				last_q      <= 1'b1;
				count_out_q <= COUNT_W'(DEPTH);
			end
			ST_EMIT: begin
				if (ready_rel) begin
					pend_time_q   <= cell_time[0];
					pend_handle_q <= cell_handle[0];
					pend_count_q  <= count_q - CNT_W'(1);
					kind_q        <= KIND_RELEASE;
					time_q        <= OUT_TIME_W'(pend_time_q);
					handle_q      <= pend_handle_q;
					last_q        <= 1'b0;
					count_out_q   <= COUNT_W'(pend_count_q);
				end else if (pend_valid_q) begin
					kind_q      <= KIND_RELEASE;
					time_q      <= OUT_TIME_W'(pend_time_q);
					handle_q    <= pend_handle_q;
					last_q      <= 1'b1;
					count_out_q <= COUNT_W'(pend_count_q);
				end else begin
					kind_q      <= KIND_NONE;
					time_q      <= '0;
					handle_q    <= '0;
					last_q      <= 1'b1;
					count_out_q <= COUNT_W'(count_q);
				end
			end
			default: ;
		endcase
	end

	assign result_valid = strobe_q;
	assign kind         = kind_q;
	assign out_time     = time_q;
	assign out_handle   = handle_q;
	assign last         = last_q;
	assign held_count   = count_out_q;

endmodule
`default_nettype wire

[tb/time_window_hit_sorter_unit_tb.sv]
`default_nettype none
module time_window_hit_sorter_unit_tb;
	import tws_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int TIME_W      = TIME_BITS_DEF;
	// no cycle should pass without a handshake for this long; the worst
	// correct case is a full flush plus the longest drawn gap
	localparam int STALL_LIMIT = 2000;
	// unused opcode, the block must drop it silently
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [TIME_W-1:0]   t;
		logic [HANDLE_W-1:0] h;
	} cmd_word_t;

	typedef struct packed {
		logic [TIME_W-1:0]   t;
		logic [HANDLE_W-1:0] h;
	} hit_t;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [OUT_TIME_W-1:0] t;
		logic [HANDLE_W-1:0]   h;
		logic                  last;
		logic [COUNT_W-1:0]    count;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  start = 1'b0;
	logic                  busy;
	logic [CMD_W-1:0]      command = CMD_INSERT;
	logic [TIME_W-1:0]     hit_time = '0;
	logic [HANDLE_W-1:0]   hit_handle = '0;

	logic                  result_valid;
	logic [KIND_W-1:0]     kind;
	logic [OUT_TIME_W-1:0] out_time;
	logic [HANDLE_W-1:0]   out_handle;
	logic                  last;
	logic [COUNT_W-1:0]    held_count;

	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW;
	logic [WIN_W-1:0]      cfg_data = '0;

	// command words waiting for the driver, oldest first
	cmd_word_t    word_q[$];
	// mirror of the sorted hit store, oldest hit at index 0
	hit_t         held_q[$];
	// result words the block still owes us, in order
	result_word_t due_q[$];

	// mirrored config registers
	logic [WIN_W-1:0] window_cfg = WINDOW_RST;
	logic             flush_cfg = 1'b0;

	int fail_count  = 0;
	int gap_left    = 0;
	int burst_left  = 0;
	int idle_cycles = 0;

	time_window_hit_sorter_unit #(
		.DEPTH(DEPTH),
		.TIME_BITS(TIME_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.hit_time(hit_time),
		.hit_handle(hit_handle),
		.result_valid(result_valid),
		.kind(kind),
		.out_time(out_time),
		.out_handle(out_handle),
		.last(last),
		.held_count(held_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// Apply one accepted command word to the store mirror and queue up
	// whatever result words it should produce.
	function automatic void advance_sorter(cmd_word_t w);
		int           pos;
		int           n;
		hit_t         entry;
		result_word_t r;
		case (w.cmd)
			CMD_INSERT: begin
				if (held_q.size() >= DEPTH) begin
					// store full: hit bounces straight back
					r.kind  = KIND_REJECT;
					r.t     = w.t;
					r.h     = w.h;
					r.last  = 1'b1;
					r.count = COUNT_W'(DEPTH);
					due_q.insert(due_q.size(), r);
				end else begin
					// goes after every hit with time <= its own, so ties keep
					// arrival order
					pos = held_q.size();
					while (pos > 0 && held_q[pos-1].t > w.t)
						pos--;
					entry.t = w.t;
					entry.h = w.h;
					held_q.insert(pos, entry);
				end
			end
			CMD_EMIT: begin
				n = 0;
				// release oldest while flushing, or while the held span is
				// strictly wider than the window (needs two or more hits)
				while (held_q.size() != 0 && (flush_cfg || (held_q.size() > 1 &&
						held_q[held_q.size()-1].t - held_q[0].t > window_cfg))) begin
					r.kind = KIND_RELEASE;
					r.t    = held_q[0].t;
					r.h    = held_q[0].h;
					r.last = 1'b0;
					held_q.delete(0);
					r.count = COUNT_W'(held_q.size());
					due_q.insert(due_q.size(), r);
					n++;
				end
				if (n == 0) begin
					r.kind  = KIND_NONE;
					r.t     = '0;
					r.h     = '0;
					r.last  = 1'b1;
					r.count = COUNT_W'(held_q.size());
					due_q.insert(due_q.size(), r);
				end else begin
					due_q[due_q.size()-1].last = 1'b1;
				end
			end
			CMD_CLEAR: held_q.delete();
			default: ;  // unused opcode: nothing happens
		endcase
	endfunction

	function automatic void queue_word(logic [CMD_W-1:0] c, logic [TIME_W-1:0] t,
			logic [HANDLE_W-1:0] h);
		cmd_word_t w;
		w.cmd = c;
		w.t   = t;
		w.h   = h;
		word_q.insert(word_q.size(), w);
	endfunction

	// Random command words. Times cluster at base+[0,spread] so the window
	// comparison sees both sides; one in eight is a full-width random time.
	function automatic void queue_random(int count, int ins_pct, logic [TIME_W-1:0] base,
			int unsigned spread);
		int               pick;
		logic [CMD_W-1:0] c;
		logic [63:0]      wide;
		logic [TIME_W-1:0] t;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < ins_pct)
				c = CMD_INSERT;
			else if (pick < ins_pct + 3)
				c = CMD_CLEAR;
			else if (pick < ins_pct + 5)
				c = CMD_UNUSED;
			else
				c = CMD_EMIT;
			if ($urandom_range(0, 7) == 0) begin
				wide = {$urandom, $urandom};
				t = wide[TIME_W-1:0];
			end else begin
				t = base + $urandom_range(0, spread);
			end
			queue_word(c, t, $urandom);
		end
	endfunction

	// Block is quiet: every word sent, every result back, busy low, and a
	// margin for an insert or clear that owes no result.
	task automatic settle();
		while (word_q.size() != 0 || due_q.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_WINDOW)
			window_cfg = data;
		else
			flush_cfg = data[0];
	endtask

	// Command driver: presents queued words, draws a random gap
	// after each accepted word, with occasional back-to-back bursts.
	always @(posedge clk) begin : word_driver
		logic hold;
		hold = start;
		if (arst_n) begin
			if (start && !busy) begin
				advance_sorter(word_q[0]);
				word_q.delete(0);
				hold = 1'b0;
				if (burst_left > 0) begin
					burst_left--;
					gap_left = 0;
				end else if ($urandom_range(0, 9) == 0) begin
					burst_left = $urandom_range(5, 20);
					gap_left = 0;
				end else begin
					gap_left = $urandom_range(0, 16);
				end
			end
			if (!hold) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (word_q.size() != 0) begin
					command    <= word_q[0].cmd;
					hit_time   <= word_q[0].t;
					hit_handle <= word_q[0].h;
					hold = 1'b1;
				end
			end
			start <= hold;
		end
	end

	// Result monitor: every strobed word must match the oldest one owed.
	always @(posedge clk) begin : result_monitor
		result_word_t want;
		if (arst_n && result_valid) begin
			if (due_q.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result word: kind=%0d time=%h handle=%h last=%b count=%0d",
						kind, out_time, out_handle, last, held_count);
				fail_count++;
			end else begin
				want = due_q[0];
				due_q.delete(0);
				if (kind !== want.kind || out_time !== want.t || out_handle !== want.h ||
						last !== want.last || held_count !== want.count) begin
					if (fail_count < 10)
						$display("result mismatch: want kind=%0d time=%h handle=%h last=%b count=%0d",
							want.kind, want.t, want.h, want.last, want.count,
							"\n                  got  kind=%0d time=%h handle=%h last=%b count=%0d",
							kind, out_time, out_handle, last, held_count);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [63:0] wide;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on reset config (window 1 s, no flush).
		queue_word(CMD_EMIT, '0, '0);                       // empty store: nothing eligible
		queue_word(CMD_INSERT, 48'd500, 32'hFFFF_FFFF);
		queue_word(CMD_INSERT, 48'd500, 32'h0000_0001);     // equal time lands behind
		queue_word(CMD_INSERT, 48'd100, 32'h0000_0000);
		queue_word(CMD_INSERT, 48'd0, 32'h5A5A_5A5A);
		queue_word(CMD_EMIT, '0, '0);                       // span far below window
		queue_word(CMD_INSERT, 48'd1_000_000_100, 32'h0000_0002);
		queue_word(CMD_EMIT, '0, '0);                       // drops one, stops at span == window
		queue_word(CMD_UNUSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(CMD_INSERT, 48'hFFFF_FFFF_FFFF, 32'hA5A5_A5A5);
		queue_word(CMD_EMIT, '0, '0);                       // drains down to the single newest
		queue_word(CMD_EMIT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF); // one hit held: nothing
		queue_word(CMD_CLEAR, '0, '0);
		queue_word(CMD_EMIT, '0, '0);
		queue_word(CMD_INSERT, 48'd0, 32'h0000_0007);
		queue_word(CMD_INSERT, 48'd0, 32'h0000_0008);
		queue_word(CMD_EMIT, '0, '0);                       // zero span
		queue_word(CMD_CLEAR, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		queue_word(CMD_EMIT, '0, '0);
		settle();

		// zero window: any spread releases, ties hold
		write_reg(REG_WINDOW, '0);
		queue_random(25, 60, 48'h0000_1234_0000, 6);
		settle();

		// widest window: nothing ever qualifies, store fills and rejects
		write_reg(REG_WINDOW, '1);
		queue_random(45, 85, '0, 32'hFFFF_FFFF);
		settle();

		// flush: first emit drains whatever is held, likely a full store
		wide = {$urandom, $urandom};
		write_reg(REG_FLUSH, {wide[WIN_W-1:1], 1'b1});
		queue_word(CMD_EMIT, '0, '0);
		queue_random(29, 55, 48'h0000_0000_8000, 1000);
		settle();

		// small window around a mid-range base
		wide = {$urandom, $urandom};
		write_reg(REG_FLUSH, {wide[WIN_W-1:1], 1'b0});
		write_reg(REG_WINDOW, 48'd1000);
		queue_random(30, 60, 48'h7FFF_FFFF_0000, 3000);
		settle();

		// random window against random base and spread
		write_reg(REG_WINDOW, WIN_W'($urandom));
		wide = {$urandom, $urandom};
		queue_random(20, 65, wide[TIME_W-1:0], $urandom);

		while (word_q.size() != 0 || due_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && due_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
